[rtl/core/rrits_pkg.sv]
// ----------------------------------------------------------------------------
// rrits_pkg
// Shared types and codes for the round robin interval task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrits_pkg;

    localparam int ID_W   = 8;
    localparam int TICK_W = 15;

    localparam logic [TICK_W-1:0] WAIT_MAX = '1;

    // Command codes
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_ADD      = 3'd1;
    localparam logic [2:0] CMD_DISPATCH = 3'd2;
    localparam logic [2:0] CMD_SLEEP    = 3'd3;
    localparam logic [2:0] CMD_SUSPEND  = 3'd4;
    localparam logic [2:0] CMD_FINISH   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [ID_W-1:0]   task_id;
        logic [TICK_W-1:0] interval_ticks;
        logic [TICK_W-1:0] sleep_ticks;
    } req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] chosen_id;
        logic [2:0]      chosen_slot;
        logic [3:0]      tasks_held;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TICK_W-1:0] interval;
        logic [TICK_W-1:0] waited;
        logic [TICK_W-1:0] sleep;
        logic              suspended;
    } entry_t;

endpackage

[rtl/core/round_robin_interval_task_scheduler.sv]
// ----------------------------------------------------------------------------
// round_robin_interval_task_scheduler
// Task table in a single-port-write memory, walked one entry at a time by a
// small sequencer for tick, dispatch, sleep, suspend and finish commands.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  cmd      | in        | cmd_valid/cmd_stall | rrits_pkg::req_t cmd_data
//  res      | out       | res_valid/res_stall | rrits_pkg::rsp_t res_data
//
//  One command at a time; a result per command. Add and empty-table cases go
//  from the start state straight to the done state, which registers the result.
//  Tick walks every entry, finish the entries after the active one, in turn
//  through a read and an evaluate state; dispatch walks the candidates the same
//  way, and sleep and suspend first update the active entry. The registered table memory read sets the pace.
//  Reset clears the task count and active slot; no clearing pass.
//  A new command is taken only after the previous result has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_interval_task_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  rrits_pkg::req_t cmd_data,
    output logic            res_valid,
    input  logic            res_stall,
    output rrits_pkg::rsp_t res_data
);
    import rrits_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_START = 5'b00010,
        S_READ  = 5'b00100,
        S_EVAL  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  active_reg, active_next;
    logic              pick_reg, pick_next;
    logic              out_valid_reg, out_valid_next;

    req_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  steps_reg, steps_next;
    logic [1:0]        status_reg, status_next;
    logic [ID_W-1:0]   chosen_reg, chosen_next;
    rsp_t              out_reg, out_next;

    entry_t            mem [MAX_TASKS];
    entry_t            rd_data_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;

    logic              accept;
    logic [CNT_W-1:0]  act_inc;
    logic [IDX_W-1:0]  start_slot;
    logic [CNT_W-1:0]  ptr_inc;
    logic              eligible;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    // first slot after the active one, modulo the task count
    assign act_inc = CNT_W'(active_reg) + CNT_W'(1);
    always_comb
    begin
        if (count_reg == CNT_W'(1))
        begin
            start_slot = '0;
        end
        else if (act_inc >= count_reg)
        begin
            start_slot = IDX_W'(act_inc - count_reg);
        end
        else
        begin
            start_slot = IDX_W'(act_inc);
        end
    end

    assign ptr_inc  = CNT_W'(ptr_reg) + CNT_W'(1);
    assign eligible = !rd_data_reg.suspended
                      && (rd_data_reg.sleep <= rd_data_reg.waited)
                      && (rd_data_reg.interval <= rd_data_reg.waited);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        active_next    = active_reg;
        pick_next      = pick_reg;
        out_valid_next = out_valid_reg;
        cmd_next       = cmd_reg;
        ptr_next       = ptr_reg;
        steps_next     = steps_reg;
        status_next    = status_reg;
        chosen_next    = chosen_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = rd_data_reg;

        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd_data;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                status_next = ST_OK;
                chosen_next = '0;
                pick_next   = 1'b0;
                steps_next  = '0;
                state_next  = S_DONE;
                case (cmd_reg.cmd)
                    CMD_TICK:
                    begin
                        if (count_reg != '0)
                        begin
                            ptr_next   = '0;
                            state_next = S_READ;
                        end
                    end
                    CMD_ADD:
                    begin
                        if (count_reg == CNT_W'(MAX_TASKS))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we              = 1'b1;
                            mem_waddr           = IDX_W'(count_reg);
                            mem_wdata.id        = cmd_reg.task_id;
                            mem_wdata.interval  = cmd_reg.interval_ticks;
                            mem_wdata.waited    = '0;
                            mem_wdata.sleep     = '0;
                            mem_wdata.suspended = 1'b0;
                            count_next          = count_reg + CNT_W'(1);
                        end
                    end
                    CMD_DISPATCH:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            pick_next  = 1'b1;
                            ptr_next   = start_slot;
                            state_next = S_READ;
                        end
                    end
                    CMD_SLEEP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (CNT_W'(active_reg) < count_reg)
                        begin
                            ptr_next   = active_reg;
                            state_next = S_READ;
                        end
                        else
                        begin
                            pick_next  = 1'b1;
                            ptr_next   = start_slot;
                            state_next = S_READ;
                        end
                    end
                    CMD_SUSPEND:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (CNT_W'(active_reg) < count_reg)
                        begin
                            ptr_next   = active_reg;
                            state_next = S_READ;
                        end
                    end
                    CMD_FINISH:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else if (CNT_W'(active_reg) < count_reg)
                        begin
                            if (act_inc == count_reg)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                ptr_next   = IDX_W'(act_inc);
                                state_next = S_READ;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_READ:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (pick_reg)
                begin
                    if (eligible)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata.waited = '0;
                        mem_wdata.sleep  = '0;
                        active_next      = ptr_reg;
                        chosen_next      = rd_data_reg.id;
                        state_next       = S_DONE;
                    end
                    else if (steps_reg + CNT_W'(1) == count_reg)
                    begin
                        status_next = ST_NONE;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        steps_next = steps_reg + CNT_W'(1);
                        ptr_next   = (ptr_inc == count_reg) ? '0 : IDX_W'(ptr_inc);
                        state_next = S_READ;
                    end
                end
                else
                begin
                    case (cmd_reg.cmd)
                        CMD_TICK:
                        begin
                            mem_we = 1'b1;
                            if (rd_data_reg.waited != WAIT_MAX)
                            begin
                                mem_wdata.waited = rd_data_reg.waited + TICK_W'(1);
                            end
                            if (ptr_inc == count_reg)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = IDX_W'(ptr_inc);
                                state_next = S_READ;
                            end
                        end
                        CMD_SLEEP:
                        begin
                            mem_we           = 1'b1;
                            mem_wdata.waited = '0;
                            mem_wdata.sleep  = cmd_reg.sleep_ticks;
                            pick_next        = 1'b1;
                            ptr_next         = start_slot;
                            state_next       = S_READ;
                        end
                        CMD_SUSPEND:
                        begin
                            mem_we              = 1'b1;
                            mem_wdata.suspended = 1'b1;
                            state_next          = S_DONE;
                        end
                        CMD_FINISH:
                        begin
                            // move this entry down one slot
                            mem_we    = 1'b1;
                            mem_waddr = ptr_reg - IDX_W'(1);
                            if (ptr_inc == count_reg)
                            begin
                                count_next = count_reg - CNT_W'(1);
                                state_next = S_DONE;
                            end
                            else
                            begin
                                ptr_next   = IDX_W'(ptr_inc);
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                out_next.status      = status_reg;
                out_next.chosen_id   = (status_reg == ST_OK) ? chosen_reg : '0;
                out_next.chosen_slot = 3'(active_reg);
                out_next.tasks_held  = 4'(count_reg);
                out_valid_next       = 1'b1;
                state_next           = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            active_reg    <= '0;
            pick_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            active_reg    <= active_next;
            pick_reg      <= pick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        ptr_reg    <= ptr_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
        chosen_reg <= chosen_next;
        out_reg    <= out_next;
    end

    // task table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[ptr_reg];
    end

endmodule

[rtl/core/rrits_checker.sv]
// ----------------------------------------------------------------------------
// rrits_checker
// Port-level checks for the round robin interval task scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrits_checker #(
    parameter int MAX_TASKS = 8
) (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_stall,
    input logic            res_valid,
    input logic            res_stall,
    input rrits_pkg::rsp_t res_data
);
    import rrits_pkg::*;

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // take no transaction while a result waits
    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cmd_stall)
        else $error("command taken while a result is pending");

    // no result right after a command transaction
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> !res_valid)
        else $error("result appeared too early");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.tasks_held <= 4'(MAX_TASKS))
        else $error("task count beyond table size");

    a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status != ST_OK |-> res_data.chosen_id == '0)
        else $error("chosen id set on a failed command");

endmodule

bind round_robin_interval_task_scheduler rrits_checker #(.MAX_TASKS(MAX_TASKS)) u_rrits_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for round_robin_interval_task_scheduler. A shadow copy
// of the task table predicts every result. Both channels idle and stall at
// random around the transactions.
// Stimulus runs in four parts: empty-table commands, a short run of back to
// back ticks followed by dispatches at the largest intervals, filling and
// overfilling the table, then random command mixes with small intervals so
// tasks keep turning eligible.
// ----------------------------------------------------------------------------

module testbench;
    import rrits_pkg::*;

    localparam int NUM_SLOTS    = 8;
    localparam int SOAK_TICKS   = 40;
    localparam int RAND_CMDS    = 1150;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;

    class sched_shadow;
        entry_t slots[NUM_SLOTS];
        int     held;
        int     active;
        rsp_t   awaited[$];
        int     errors;
        int     noted;
        int     checked;
        int     by_status[4];

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR: %s", msg);
        endfunction

        // Walk from the slot after the active one; clear and activate the first ready task.
        function logic [1:0] pick_eligible(output logic [ID_W-1:0] id);
            int s;
            id = '0;
            if (held == 0)
                return ST_EMPTY;
            for (int step = 1; step <= held; step++)
            begin
                s = (active + step) % held;
                if (slots[s].suspended || slots[s].sleep > slots[s].waited
                    || slots[s].interval > slots[s].waited)
                    continue;
                slots[s].sleep  = '0;
                slots[s].waited = '0;
                active = s;
                id = slots[s].id;
                return ST_OK;
            end
            return ST_NONE;
        endfunction

        function void note_cmd(req_t r);
            logic [1:0]      st;
            logic [ID_W-1:0] pick;
            rsp_t            want;
            st   = ST_OK;
            pick = '0;
            noted++;
            case (r.cmd)
                CMD_TICK:
                    for (int i = 0; i < held; i++)
                        if (slots[i].waited != WAIT_MAX)
                            slots[i].waited = slots[i].waited + 1'b1;
                CMD_ADD:
                    if (held >= NUM_SLOTS)
                        st = ST_FULL;
                    else
                    begin
                        slots[held].id        = r.task_id;
                        slots[held].interval  = r.interval_ticks;
                        slots[held].waited    = '0;
                        slots[held].sleep     = '0;
                        slots[held].suspended = 1'b0;
                        held++;
                    end
                CMD_DISPATCH:
                    st = pick_eligible(pick);
                CMD_SLEEP:
                    if (held == 0)
                        st = ST_EMPTY;
                    else
                    begin
                        // active slot may lie past the end after a finish: skip the write
                        if (active < held)
                        begin
                            slots[active].waited = '0;
                            slots[active].sleep  = r.sleep_ticks;
                        end
                        st = pick_eligible(pick);
                    end
                CMD_SUSPEND:
                    if (held == 0)
                        st = ST_EMPTY;
                    else if (active < held)
                        slots[active].suspended = 1'b1;
                CMD_FINISH:
                    if (held == 0)
                        st = ST_EMPTY;
                    else if (active < held)
                    begin
                        // shift later entries down; active keeps its number
                        for (int i = active; i + 1 < held; i++)
                            slots[i] = slots[i + 1];
                        held--;
                    end
                default: ;
            endcase
            if (st != ST_OK)
                pick = '0;
            want.status      = st;
            want.chosen_id   = pick;
            want.chosen_slot = 3'(active);
            want.tasks_held  = 4'(held);
            awaited.push_back(want);
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                flag($sformatf("result with nothing awaited: status %0d id %0h slot %0d held %0d",
                               got.status, got.chosen_id, got.chosen_slot, got.tasks_held));
                return;
            end
            want = awaited.pop_front();
            checked++;
            by_status[want.status]++;
            if (got.status !== want.status || got.chosen_id !== want.chosen_id
                || got.chosen_slot !== want.chosen_slot || got.tasks_held !== want.tasks_held)
                flag($sformatf({"result %0d: expected status %0d id %0h slot %0d held %0d, ",
                                "got status %0d id %0h slot %0d held %0d"},
                               checked, want.status, want.chosen_id, want.chosen_slot,
                               want.tasks_held, got.status, got.chosen_id, got.chosen_slot,
                               got.tasks_held));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    req_t        cmd_data;
    logic        res_valid;
    logic        res_stall;
    rsp_t        res_data;
    sched_shadow shadow;
    bit          quiet;
    int          idle_cycles = 0;

    round_robin_interval_task_scheduler #(
        .MAX_TASKS(NUM_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd_data(cmd_data),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res_data(res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                shadow.note_cmd(cmd_data);
            if (res_valid && !res_stall)
                shadow.check_result(res_data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL round_robin_interval_task_scheduler");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Result side: stall for a random count of cycles, then take one transaction.
    initial
    begin : result_sink
        int hold;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = quiet ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                @(negedge clk);
                res_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                res_stall <= 1'b0;
            end
            do @(posedge clk); while (!res_valid);
        end
    end

    // Hold valid across back-to-back transactions; drop it only for a gap.
    task automatic send_cmd(input logic [2:0] op, input logic [ID_W-1:0] id,
                            input logic [TICK_W-1:0] ivl, input logic [TICK_W-1:0] slp);
        int   gap;
        req_t r;
        gap = quiet ? 0 : $urandom_range(0, 9);
        r.cmd            = op;
        r.task_id        = id;
        r.interval_ticks = ivl;
        r.sleep_ticks    = slp;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= r;
        do @(posedge clk); while (cmd_stall);
    endtask

    initial
    begin : stimulus
        int                i;
        int                roll;
        logic [2:0]        op;
        logic [TICK_W-1:0] ivl;
        logic [TICK_W-1:0] slp;
        shadow    = new();
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_data  = '0;
        quiet     = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty table
        send_cmd(CMD_DISPATCH, 8'h00, '0, '0);
        send_cmd(CMD_SLEEP, 8'h00, '0, TICK_W'(5));
        send_cmd(CMD_SUSPEND, 8'h00, '0, '0);
        send_cmd(CMD_FINISH, 8'h00, '0, '0);
        send_cmd(CMD_TICK, 8'h00, '0, '0);

        // back to back ticks, then dispatch at the largest intervals
        send_cmd(CMD_ADD, 8'hFF, WAIT_MAX, '0);
        send_cmd(CMD_ADD, 8'h00, WAIT_MAX - TICK_W'(1), '0);
        quiet = 1'b1;
        for (i = 0; i < SOAK_TICKS; i++)
            send_cmd(CMD_TICK, ID_W'($urandom), TICK_W'($urandom), TICK_W'($urandom));
        send_cmd(CMD_DISPATCH, 8'h00, '0, '0);
        send_cmd(CMD_DISPATCH, 8'h00, '0, '0);
        quiet = 1'b0;

        // fill the table; the last add overflows
        for (i = 0; i < 7; i++)
            send_cmd(CMD_ADD, ID_W'(8'h11 * i + 1), TICK_W'(i % 3), '0);
        send_cmd(CMD_SLEEP, 8'h00, '0, WAIT_MAX);
        send_cmd(CMD_SLEEP, 8'h00, '0, '0);
        send_cmd(CMD_SUSPEND, 8'h00, '0, '0);
        send_cmd(CMD_TICK, 8'h00, '0, '0);
        send_cmd(CMD_TICK, 8'h00, '0, '0);
        send_cmd(CMD_DISPATCH, 8'h00, '0, '0);
        send_cmd(CMD_FINISH, 8'h00, '0, '0);
        send_cmd(CMD_DISPATCH, 8'h00, '0, '0);

        // random mix; mostly short intervals and sleeps so tasks come due
        for (i = 0; i < RAND_CMDS; i++)
        begin
            if (i % 150 == 0)
                quiet = ((i / 150) % 4 == 3);
            roll = $urandom_range(0, 99);
            if (roll < 36)
                op = CMD_TICK;
            else if (roll < 52)
                op = CMD_ADD;
            else if (roll < 76)
                op = CMD_DISPATCH;
            else if (roll < 86)
                op = CMD_SLEEP;
            else if (roll < 91)
                op = CMD_SUSPEND;
            else
                op = CMD_FINISH;
            ivl = ($urandom_range(0, 19) == 0) ? TICK_W'($urandom)
                                               : TICK_W'($urandom_range(0, 6));
            slp = ($urandom_range(0, 19) == 0) ? TICK_W'($urandom)
                                               : TICK_W'($urandom_range(0, 5));
            send_cmd(op, ID_W'($urandom), ivl, slp);
        end
        quiet = 1'b0;
        @(negedge clk);
        cmd_valid <= 1'b0;

        while (shadow.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d commands (a %0d-tick back to back run among them), %0d results checked.",
                 shadow.noted, SOAK_TICKS, shadow.checked);
        $display("Statuses: ok %0d, table full %0d, none eligible %0d, table empty %0d; errors %0d.",
                 shadow.by_status[ST_OK], shadow.by_status[ST_FULL],
                 shadow.by_status[ST_NONE], shadow.by_status[ST_EMPTY], shadow.errors);
        if (shadow.errors == 0)
            $display("PASS round_robin_interval_task_scheduler");
        else
            $display("FAIL round_robin_interval_task_scheduler");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rrits_pkg.sv
rtl/core/round_robin_interval_task_scheduler.sv
rtl/core/rrits_checker.sv
tb/testbench.sv
